### src/rational_fraction_alu_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rational fraction ALU core
// Clocked property checks that drop out when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef RATIONAL_FRACTION_ALU_CORE_DEFINES_SVH
`define RATIONAL_FRACTION_ALU_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// lbl: label, prop: property expression, msg: message string
`define RFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RFA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RFA_ASSERT(lbl, prop, msg)
`define RFA_NEVER(lbl, expr, msg)
`endif

`endif

### src/rfa_pkg.sv
// ---------------------------------------------------------------------------
// rfa_pkg
// Widths, codes and shared types of the rational fraction ALU.
// ---------------------------------------------------------------------------
package rfa_pkg;

  localparam int OPERAND_BITS = 28;
  localparam int LIMIT_BITS   = 27;
  localparam int NUM_BITS     = 56;
  localparam int DEN_BITS     = 55;
  localparam int CNT_BITS     = $clog2(NUM_BITS + 1);

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(100000000);

  // operation codes of an item
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  // shared unit operations
  localparam logic [1:0] UOP_MUL = 2'd0;
  localparam logic [1:0] UOP_DIV = 2'd1;
  localparam logic [1:0] UOP_GCD = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // magnitude of a two's complement operand
  function automatic logic [OPERAND_BITS-1:0] op_mag(input logic [OPERAND_BITS-1:0] v);
    op_mag = v[OPERAND_BITS-1] ? (~v + OPERAND_BITS'(1)) : v;
  endfunction

endpackage

### src/rational_fraction_alu_core.sv
// ---------------------------------------------------------------------------
// rational_fraction_alu_core
// Add, subtract, multiply or divide two signed fractions, result fully reduced.
// ---------------------------------------------------------------------------
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid/in_ready, action, num/den a and b    | to core
//  out     | out_valid/out_ready, result_num/den, error    | from core
//  cfg     | cfg_valid/cfg_ready, cfg_data (operand_limit) | to core
//
// One item at a time. A rejected item goes straight to the output state. Every
// pass through the shared multiply/divide/GCD unit adds a handoff to its work.
// Add and subtract need three products, multiply and divide two; a zero
// numerator then goes straight to the output state, anything else adds a GCD
// and two divides.
// Synchronous active low reset; operand_limit resets to 100000000.
// A stalled result waits in the output register; the next item is taken
// only once the core is back in idle.
// ---------------------------------------------------------------------------
`include "rational_fraction_alu_core_defines.svh"

module rational_fraction_alu_core
  import rfa_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic signed [OPERAND_BITS-1:0] in_num_a,
  input  logic signed [OPERAND_BITS-1:0] in_den_a,
  input  logic signed [OPERAND_BITS-1:0] in_num_b,
  input  logic signed [OPERAND_BITS-1:0] in_den_b,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [NUM_BITS-1:0]     out_result_num,
  output logic [DEN_BITS-1:0]            out_result_den,
  output logic                           out_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [LIMIT_BITS-1:0]          cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL_D = 4'd1;
  localparam logic [3:0] S_MUL_X = 4'd2;
  localparam logic [3:0] S_MUL_Y = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_GCD   = 4'd5;
  localparam logic [3:0] S_DIV_N = 4'd6;
  localparam logic [3:0] S_DIV_D = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  localparam int CMP_BITS = OPERAND_BITS + LIMIT_BITS;
  localparam int SUM_BITS = NUM_BITS + 1;

  logic [3:0]              state_r, state_nxt;
  logic                    go_r, go_nxt;
  logic [LIMIT_BITS-1:0]   limit_r;
  logic [1:0]              act_r, act_nxt;
  logic [OPERAND_BITS-1:0] mn1_r, mn1_nxt, md1_r, md1_nxt;
  logic [OPERAND_BITS-1:0] mn2_r, mn2_nxt, md2_r, md2_nxt;
  logic                    sx_r, sx_nxt, sy_r, sy_nxt, sd_r, sd_nxt;
  logic [NUM_BITS-1:0]     dmag_r, dmag_nxt, px_r, px_nxt, py_r, py_nxt;
  logic [NUM_BITS-1:0]     nmag_r, nmag_nxt, g_r, g_nxt;
  logic [NUM_BITS-1:0]     rn_r, rn_nxt, rd_r, rd_nxt;
  logic                    neg_r, neg_nxt, err_r, err_nxt;
  logic                    ov_r, ov_nxt;
  logic [NUM_BITS-1:0]     on_r, on_nxt;
  logic [DEN_BITS-1:0]     od_r, od_nxt;
  logic                    oe_r, oe_nxt;

  logic [OPERAND_BITS-1:0] m_n1, m_d1, m_n2, m_d2;
  logic [CMP_BITS-1:0]     lim_ext;
  logic                    bad_in;
  logic                    unit_state;
  unit_ctl_t               u_ctl;
  unit_stat_t              u_stat;
  logic [NUM_BITS-1:0]     u_a, u_b, u_res;
  logic [SUM_BITS-1:0]     sxv, syv, nsum, nabs;

  assign m_n1    = op_mag(in_num_a);
  assign m_d1    = op_mag(in_den_a);
  assign m_n2    = op_mag(in_num_b);
  assign m_d2    = op_mag(in_den_b);
  assign lim_ext = {{OPERAND_BITS{1'b0}}, limit_r};

  // reject range, zero denominator, zero divisor
  assign bad_in = ({{LIMIT_BITS{1'b0}}, m_n1} > lim_ext) ||
                  ({{LIMIT_BITS{1'b0}}, m_d1} > lim_ext) ||
                  ({{LIMIT_BITS{1'b0}}, m_n2} > lim_ext) ||
                  ({{LIMIT_BITS{1'b0}}, m_d2} > lim_ext) ||
                  (in_den_a == '0) || (in_den_b == '0) ||
                  ((in_action == ACT_DIV) && (in_num_b == '0));

  // signed numerator from the two cross products
  assign sxv  = sx_r ? (SUM_BITS'(0) - {1'b0, px_r}) : {1'b0, px_r};
  assign syv  = sy_r ? (SUM_BITS'(0) - {1'b0, py_r}) : {1'b0, py_r};
  assign nsum = sxv + syv;
  assign nabs = nsum[SUM_BITS-1] ? (SUM_BITS'(0) - nsum) : nsum;

  assign unit_state = state_r inside {S_MUL_D, S_MUL_X, S_MUL_Y, S_GCD, S_DIV_N, S_DIV_D};

  // operand select for the shared unit
  always_comb begin
    u_ctl.start = unit_state && !go_r;
    u_ctl.op    = UOP_MUL;
    u_a         = '0;
    u_b         = '0;
    case (state_r)
      S_MUL_D: begin
        u_a = NUM_BITS'(md1_r);
        u_b = (act_r == ACT_DIV) ? NUM_BITS'(mn2_r) : NUM_BITS'(md2_r);
      end
      S_MUL_X: begin
        u_a = NUM_BITS'(mn1_r);
        u_b = (act_r == ACT_MUL) ? NUM_BITS'(mn2_r) : NUM_BITS'(md2_r);
      end
      S_MUL_Y: begin
        u_a = NUM_BITS'(mn2_r);
        u_b = NUM_BITS'(md1_r);
      end
      S_GCD: begin
        u_ctl.op = UOP_GCD;
        u_a      = nmag_r;
        u_b      = dmag_r;
      end
      S_DIV_N: begin
        u_ctl.op = UOP_DIV;
        u_a      = nmag_r;
        u_b      = g_r;
      end
      S_DIV_D: begin
        u_ctl.op = UOP_DIV;
        u_a      = dmag_r;
        u_b      = g_r;
      end
      default: begin
        u_ctl.op = UOP_MUL;
      end
    endcase
  end

  rfa_iter_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (u_ctl),
    .opa   (u_a),
    .opb   (u_b),
    .stat  (u_stat),
    .res   (u_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    go_nxt    = go_r;
    act_nxt   = act_r;
    mn1_nxt   = mn1_r;
    md1_nxt   = md1_r;
    mn2_nxt   = mn2_r;
    md2_nxt   = md2_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    sd_nxt    = sd_r;
    dmag_nxt  = dmag_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    nmag_nxt  = nmag_r;
    g_nxt     = g_r;
    rn_nxt    = rn_r;
    rd_nxt    = rd_r;
    neg_nxt   = neg_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r;
    on_nxt    = on_r;
    od_nxt    = od_r;
    oe_nxt    = oe_r;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    if (u_ctl.start) go_nxt = 1'b1;
    if (u_stat.done) go_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action;
          mn1_nxt = m_n1;
          md1_nxt = m_d1;
          mn2_nxt = m_n2;
          md2_nxt = m_d2;
          sx_nxt  = in_num_a[OPERAND_BITS-1] ^
                    ((in_action == ACT_MUL) ? in_num_b[OPERAND_BITS-1]
                                            : in_den_b[OPERAND_BITS-1]);
          sy_nxt  = in_num_b[OPERAND_BITS-1] ^ in_den_a[OPERAND_BITS-1] ^
                    (in_action == ACT_SUB);
          sd_nxt  = in_den_a[OPERAND_BITS-1] ^
                    ((in_action == ACT_DIV) ? in_num_b[OPERAND_BITS-1]
                                            : in_den_b[OPERAND_BITS-1]);
          if (bad_in) begin
            err_nxt   = 1'b1;
            neg_nxt   = 1'b0;
            rn_nxt    = '0;
            rd_nxt    = '0;
            state_nxt = S_OUT;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = S_MUL_D;
          end
        end
      end
      S_MUL_D: begin
        if (u_stat.done) begin
          dmag_nxt  = u_res;
          state_nxt = S_MUL_X;
        end
      end
      S_MUL_X: begin
        if (u_stat.done) begin
          px_nxt = u_res;
          if (act_r == ACT_ADD || act_r == ACT_SUB) begin
            state_nxt = S_MUL_Y;
          end else begin
            py_nxt    = '0;
            state_nxt = S_SUM;
          end
        end
      end
      S_MUL_Y: begin
        if (u_stat.done) begin
          py_nxt    = u_res;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        nmag_nxt = nabs[NUM_BITS-1:0];
        neg_nxt  = nsum[SUM_BITS-1] ^ sd_r;
        if (nabs == '0) begin
          // zero result reads 0/1
          rn_nxt    = '0;
          rd_nxt    = NUM_BITS'(1);
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (u_stat.done) begin
          g_nxt     = u_res;
          state_nxt = S_DIV_N;
        end
      end
      S_DIV_N: begin
        if (u_stat.done) begin
          rn_nxt    = u_res;
          state_nxt = S_DIV_D;
        end
      end
      S_DIV_D: begin
        if (u_stat.done) begin
          rd_nxt    = u_res;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          on_nxt    = neg_r ? (NUM_BITS'(0) - rn_r) : rn_r;
          od_nxt    = rd_r[DEN_BITS-1:0];
          oe_nxt    = err_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r    <= 1'b0;
      ov_r    <= 1'b0;
      limit_r <= LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid) limit_r <= cfg_data;
    end
    act_r  <= act_nxt;
    mn1_r  <= mn1_nxt;
    md1_r  <= md1_nxt;
    mn2_r  <= mn2_nxt;
    md2_r  <= md2_nxt;
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    sd_r   <= sd_nxt;
    dmag_r <= dmag_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    nmag_r <= nmag_nxt;
    g_r    <= g_nxt;
    rn_r   <= rn_nxt;
    rd_r   <= rd_nxt;
    neg_r  <= neg_nxt;
    err_r  <= err_nxt;
    on_r   <= on_nxt;
    od_r   <= od_nxt;
    oe_r   <= oe_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = ov_r;
  assign out_result_num = on_r;
  assign out_result_den = od_r;
  assign out_error      = oe_r;

  `RFA_ASSERT(a_accept_leaves_idle, (in_valid && in_ready) |=> (state_r != S_IDLE), "accepted item left core idle")
  `RFA_NEVER(a_done_unrequested, u_stat.done && !go_r, "shared unit finished without a request")
  `RFA_ASSERT(a_error_zero, (out_valid && out_error) |-> (out_result_num == '0 && out_result_den == '0), "error item carries nonzero fields")
  `RFA_ASSERT(a_den_nonzero, (out_valid && !out_error) |-> (out_result_den != '0), "good item with zero denominator")

endmodule

### src/rfa_iter_unit.sv
// ---------------------------------------------------------------------------
// rfa_iter_unit
// Shared iterative unit: shift-add multiply, restoring divide, binary GCD.
// ---------------------------------------------------------------------------
module rfa_iter_unit
  import rfa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  unit_ctl_t           ctl,
  input  logic [NUM_BITS-1:0] opa,
  input  logic [NUM_BITS-1:0] opb,
  output unit_stat_t          stat,
  output logic [NUM_BITS-1:0] res
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic                fix_r, fix_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [NUM_BITS-1:0] x_r, x_nxt;
  logic [NUM_BITS-1:0] y_r, y_nxt;
  logic [NUM_BITS-1:0] acc_r, acc_nxt;
  logic [NUM_BITS-1:0] res_r, res_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0] k_r, k_nxt;
  logic [NUM_BITS:0]   rem_sh;
  logic [NUM_BITS:0]   rem_diff;
  logic [NUM_BITS:0]   xy_diff;

  assign rem_sh   = {acc_r, x_r[NUM_BITS-1]};
  assign rem_diff = rem_sh - {1'b0, y_r};
  assign xy_diff  = {1'b0, x_r} - {1'b0, y_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    fix_nxt  = fix_r;
    op_nxt   = op_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    cnt_nxt  = cnt_r;
    k_nxt    = k_r;
    if (!busy_r) begin
      if (ctl.start) begin
        busy_nxt = 1'b1;
        op_nxt   = ctl.op;
        x_nxt    = opa;
        y_nxt    = opb;
        acc_nxt  = '0;
        fix_nxt  = 1'b0;
        k_nxt    = '0;
        cnt_nxt  = (ctl.op == UOP_MUL) ? CNT_BITS'(OPERAND_BITS) : CNT_BITS'(NUM_BITS);
      end
    end else begin
      case (op_r)
        UOP_MUL: begin
          if (y_r[0]) acc_nxt = acc_r + x_r;
          x_nxt   = {x_r[NUM_BITS-2:0], 1'b0};
          y_nxt   = {1'b0, y_r[NUM_BITS-1:1]};
          cnt_nxt = cnt_r - CNT_BITS'(1);
          if (cnt_r == CNT_BITS'(1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            res_nxt  = acc_nxt;
          end
        end
        UOP_DIV: begin
          if (!rem_diff[NUM_BITS]) begin
            acc_nxt = rem_diff[NUM_BITS-1:0];
            x_nxt   = {x_r[NUM_BITS-2:0], 1'b1};
          end else begin
            acc_nxt = rem_sh[NUM_BITS-1:0];
            x_nxt   = {x_r[NUM_BITS-2:0], 1'b0};
          end
          cnt_nxt = cnt_r - CNT_BITS'(1);
          if (cnt_r == CNT_BITS'(1)) begin
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
            res_nxt  = x_nxt;
          end
        end
        UOP_GCD: begin
          if (fix_r) begin
            // restore the common power of two
            if (k_r == '0) begin
              busy_nxt = 1'b0;
              done_nxt = 1'b1;
              res_nxt  = x_r;
            end else begin
              x_nxt = {x_r[NUM_BITS-2:0], 1'b0};
              k_nxt = k_r - CNT_BITS'(1);
            end
          end else if (x_r == '0) begin
            x_nxt   = y_r;
            fix_nxt = 1'b1;
          end else if (y_r == '0) begin
            fix_nxt = 1'b1;
          end else if (!x_r[0] && !y_r[0]) begin
            x_nxt = {1'b0, x_r[NUM_BITS-1:1]};
            y_nxt = {1'b0, y_r[NUM_BITS-1:1]};
            k_nxt = k_r + CNT_BITS'(1);
          end else if (!x_r[0]) begin
            x_nxt = {1'b0, x_r[NUM_BITS-1:1]};
          end else if (!y_r[0]) begin
            y_nxt = {1'b0, y_r[NUM_BITS-1:1]};
          end else if (!xy_diff[NUM_BITS]) begin
            x_nxt = xy_diff[NUM_BITS-1:0];
          end else begin
            y_nxt = NUM_BITS'(0) - xy_diff[NUM_BITS-1:0];
          end
        end
        default: begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          res_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    fix_r <= fix_nxt;
    op_r  <= op_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    cnt_r <= cnt_nxt;
    k_r   <= k_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = res_r;

endmodule

### test/rfa_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfa_result_checker
// Watches the item, result and limit channels of the fraction ALU, predicts
// each reduced result from the accepted operands and compares in order.
// ---------------------------------------------------------------------------
module rfa_result_checker
  import rfa_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic signed [OPERAND_BITS-1:0] in_num_a,
  input  logic signed [OPERAND_BITS-1:0] in_den_a,
  input  logic signed [OPERAND_BITS-1:0] in_num_b,
  input  logic signed [OPERAND_BITS-1:0] in_den_b,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [NUM_BITS-1:0]     out_result_num,
  input  logic [DEN_BITS-1:0]            out_result_den,
  input  logic                           out_error,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [LIMIT_BITS-1:0]          cfg_data,
  output int                             fail_count,
  output int                             pending
);

  typedef struct {
    logic signed [NUM_BITS-1:0] num;
    logic [DEN_BITS-1:0]        den;
    logic                       err;
  } fraction_t;

  fraction_t       fraction_q[$];
  longint unsigned limit_shadow;

  assign pending = fraction_q.size();

  function automatic longint unsigned euclid(input longint unsigned a, input longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic longint unsigned magn(input longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  // divide out the common factor and move the sign to the numerator
  function automatic void lowest_terms(inout longint n, inout longint d);
    longint g;
    g = longint'(euclid(magn(n), magn(d)));
    if (g == 0) g = 1;
    n = n / g;
    d = d / g;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
  endfunction

  function automatic fraction_t compute_fraction(input logic [1:0] act,
      input longint n1_in, input longint d1_in, input longint n2_in, input longint d2_in);
    fraction_t r;
    longint n1, d1, n2, d2, rn, rd, l, t2, bn, bd, g;
    longint unsigned an, ad, cn, cd, g1, g2;
    logic neg;
    n1 = n1_in; d1 = d1_in; n2 = n2_in; d2 = d2_in;
    if (magn(n1) > limit_shadow || magn(d1) > limit_shadow ||
        magn(n2) > limit_shadow || magn(d2) > limit_shadow ||
        d1 == 0 || d2 == 0 || (act == ACT_DIV && n2 == 0)) begin
      r.num = '0;
      r.den = '0;
      r.err = 1'b1;
      return r;
    end
    lowest_terms(n1, d1);
    lowest_terms(n2, d2);
    if (act == ACT_ADD || act == ACT_SUB) begin
      // bring both to the least common denominator
      g  = longint'(euclid(d1, d2));
      l  = (d1 / g) * d2;
      t2 = n2 * (l / d2);
      rn = n1 * (l / d1) + ((act == ACT_SUB) ? -t2 : t2);
      rd = l;
    end else begin
      bn = n2;
      bd = d2;
      if (act == ACT_DIV) begin
        bn = d2;
        bd = n2;
      end
      neg = ((n1 < 0) != (bn < 0)) != (bd < 0);
      an = magn(n1);
      ad = d1;
      cn = magn(bn);
      cd = magn(bd);
      // cross-reduce before the multiply
      g1 = euclid(an, cd);
      g2 = euclid(cn, ad);
      if (g1 == 0) g1 = 1;
      if (g2 == 0) g2 = 1;
      an = an / g1;
      cd = cd / g1;
      cn = cn / g2;
      ad = ad / g2;
      rn = longint'(an * cn);
      rd = longint'(ad * cd);
      if (neg) rn = -rn;
    end
    lowest_terms(rn, rd);
    if (rn == 0) rd = 1;
    r.num = rn[NUM_BITS-1:0];
    r.den = rd[DEN_BITS-1:0];
    r.err = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    fraction_t want;
    if (!rst_n) begin
      limit_shadow = LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) limit_shadow = cfg_data;
      if (in_valid && in_ready)
        fraction_q.push_back(compute_fraction(in_action, in_num_a, in_den_a,
                                              in_num_b, in_den_b));
      if (out_valid && out_ready) begin
        if (fraction_q.size() == 0) begin
          $display("%0t: result item with nothing outstanding", $realtime);
          fail_count++;
        end else begin
          want = fraction_q.pop_front();
          if (out_result_num !== want.num)
            report_mismatch("result_num", out_result_num, want.num);
          if (out_result_den !== want.den)
            report_mismatch("result_den", longint'(out_result_den), longint'(want.den));
          if (out_error !== want.err)
            report_mismatch("error", longint'(out_error), longint'(want.err));
        end
      end
    end
  end

endmodule

### test/tb_rational_fraction_alu_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rational_fraction_alu_core
// Drives directed and random fraction items through the ALU under varying
// handshake pressure and limit settings; the checker predicts every result.
// ---------------------------------------------------------------------------
module tb_rational_fraction_alu_core;
  import rfa_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [1:0]                     in_action;
  logic signed [OPERAND_BITS-1:0] in_num_a;
  logic signed [OPERAND_BITS-1:0] in_den_a;
  logic signed [OPERAND_BITS-1:0] in_num_b;
  logic signed [OPERAND_BITS-1:0] in_den_b;
  logic                           out_valid;
  logic                           out_ready;
  logic signed [NUM_BITS-1:0]     out_result_num;
  logic [DEN_BITS-1:0]            out_result_den;
  logic                           out_error;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [LIMIT_BITS-1:0]          cfg_data;

  int     fail_count;
  int     pending;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_left;
  logic   hold_req;
  longint cur_limit;
  longint cycles;

  rational_fraction_alu_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_num_a       (in_num_a),
    .in_den_a       (in_den_a),
    .in_num_b       (in_num_b),
    .in_den_b       (in_den_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_num (out_result_num),
    .out_result_den (out_result_den),
    .out_error      (out_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  rfa_result_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_num_a       (in_num_a),
    .in_den_a       (in_den_a),
    .in_num_b       (in_num_b),
    .in_den_b       (in_den_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_num (out_result_num),
    .out_result_den (out_result_den),
    .out_error      (out_error),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: give up well beyond the slowest legal run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off once the stimulus asks for
  // one. The hold is counted here so the sender keeps offering items meanwhile.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      out_ready <= 1'b0;
      hold_left <= 1500;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one item; hold it until the core takes it.
  task automatic send_item(input logic [1:0] act, input longint na, input longint da,
                           input longint nb, input longint db);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_num_a  <= na[OPERAND_BITS-1:0];
    in_den_a  <= da[OPERAND_BITS-1:0];
    in_num_b  <= nb[OPERAND_BITS-1:0];
    in_den_b  <= db[OPERAND_BITS-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Wait until every outstanding result has drained.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(input longint value);
    drain();
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[LIMIT_BITS-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_limit = value;
  endtask

  // Many small values so reductions happen often; a few boundary, zero and
  // full-width values to reach the reject paths and toggle every bit.
  function automatic longint pick_operand(input longint lim);
    int     sel;
    longint v;
    sel = $urandom_range(99);
    if (sel < 4)
      v = longint'($signed(28'($urandom)));
    else if (sel < 7)
      v = 0;
    else if (sel < 10)
      v = lim + 1;
    else if (sel < 20)
      v = lim;
    else if (sel < 65)
      v = $urandom_range(60);
    else
      v = (lim == 0) ? 0 : longint'($urandom_range(32'(lim)));
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic random_items(input int count);
    longint na, da, nb, db;
    repeat (count) begin
      na = pick_operand(cur_limit);
      da = pick_operand(cur_limit);
      nb = pick_operand(cur_limit);
      db = pick_operand(cur_limit);
      send_item(2'($urandom_range(3)), na, da, nb, db);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_ADD;
    in_num_a       = '0;
    in_den_a       = '0;
    in_num_b       = '0;
    in_den_b       = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    hold_req       = 1'b0;
    send_idle_pct  = 11;
    recv_stall_pct = 77;
    cur_limit      = 100000000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operation, reductions, signs, limits and rejects.
    send_item(ACT_ADD, 1, 2, 1, 3);
    send_item(ACT_SUB, 3, 4, 6, 8);                  // equal fractions give 0/1
    send_item(ACT_MUL, -6, 4, 10, -9);
    send_item(ACT_DIV, 7, -3, -14, 9);
    send_item(ACT_DIV, 5, 3, 0, 7);                  // divide by zero
    send_item(ACT_ADD, 1, 0, 1, 2);                  // zero denominator a
    send_item(ACT_MUL, 1, 2, 3, 0);                  // zero denominator b
    send_item(ACT_MUL, 0, 5, 9, 11);                 // zero numerator
    send_item(ACT_ADD, 100000000, 1, 100000000, 1);  // at the limit
    send_item(ACT_SUB, -100000000, 1, 100000000, 1);
    send_item(ACT_MUL, 100000000, 99999999, 99999989, 100000000);
    send_item(ACT_DIV, 1, 100000000, 100000000, 1);
    send_item(ACT_ADD, 100000001, 1, 1, 1);          // just past the limit
    send_item(ACT_SUB, 1, -100000001, 1, 1);
    send_item(ACT_MUL, 134217727, 1, 1, 1);          // field extremes
    send_item(ACT_DIV, 1, 1, -134217728, 1);
    send_item(ACT_ADD, 1, 99999989, 1, 99999971);    // coprime large dens
    send_item(ACT_SUB, -5, -10, 2, -4);
    send_item(ACT_MUL, -100000000, -3, 3, -100000000);
    send_item(ACT_DIV, 0, -7, -3, 5);
    random_items(350);

    // Everything is rejected with a zero limit.
    write_limit(0);
    send_item(ACT_ADD, 0, 1, 0, 1);
    send_item(ACT_MUL, 0, 0, 0, 0);
    random_items(20);

    // Swap who idles; small limit makes many in-range items.
    write_limit(1000);
    send_idle_pct  = 77;
    recv_stall_pct = 11;
    random_items(300);

    write_limit(100000000);
    random_items(100);

    // No idling; park the receiver long while items keep coming, then pause.
    write_limit($urandom_range(100000000));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    random_items(150);
    drain();
    write_limit(100000000);
    random_items(150);

    drain();
    repeat (500) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/rfa_pkg.sv
src/rfa_iter_unit.sv
src/rational_fraction_alu_core.sv
test/rfa_result_checker.sv
test/tb_rational_fraction_alu_core.sv
